>>> hw/rtl/rbc_pkg.sv
// shared widths, constants and divider request/response types for the rgb breathe block
package rbc_pkg;

    localparam int LVL_W  = 8;
    localparam int CNT_W  = 13;
    localparam int QUO_W  = LVL_W + CNT_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    localparam logic [LVL_W-1:0] LVL_MAX = '1;

    // ceil(2^29/255): an exact quotient by 255 for every dividend below 2^21
    localparam int               RCP_W   = 22;
    localparam int               RCP_SH  = 29;
    localparam logic [RCP_W-1:0] RCP_255 = RCP_W'(2105377);

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hw/rtl/rgb_led_breathe_cycle_top.sv
// rgb led breathing / colour cycle controller: sequencer, ramp and compare state
//
// input channel (i_in_valid/o_in_ready) takes one update tick per item; i_update=0
// only reports the current compares. result channel (o_out_valid/i_out_ready) gives
// the three pwm compare values, one result per item. configuration is written through
// i_cfg_valid/o_cfg_ready with i_cfg_index 0 mode, 1..3 red/green/blue level,
// 4 pulse length; other indexes are ignored. write it only while the block is idle.
// an update outside steady mode first forms pulse length times RAMP_STEPS in the
// shared multiplier and divides it by 255 with a reciprocal multiply into the ramp
// limit; each level*count/limit then goes through the serial divider. the colour
// cycle modes do one division and breathing three; steady mode and update 0 use none.
// one item at a time: o_in_ready is high only while the sequencer is idle, so an
// item is taken only after the last one has left the sequencer; a new item is taken
// while the previous result still waits in the output register.
// when the receiver stalls, the finished result waits before leaving the sequencer.
// reset (synchronous, active low) clears the ramp, phase and compares, sets mode
// steady, levels 0 and pulse length 255.
module rgb_led_breathe_cycle_top #(
    parameter int RAMP_STEPS = 5000
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_update,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [rbc_pkg::LVL_W-1:0] o_red_duty,
    output logic [rbc_pkg::LVL_W-1:0] o_green_duty,
    output logic [rbc_pkg::LVL_W-1:0] o_blue_duty,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [rbc_pkg::LVL_W-1:0] i_cfg_data
);
    import rbc_pkg::*;

    localparam logic [CNT_W-1:0] RampSteps = CNT_W'(RAMP_STEPS);

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_RED   = 3'd1;
    localparam logic [2:0] CFG_GREEN = 3'd2;
    localparam logic [2:0] CFG_BLUE  = 3'd3;
    localparam logic [2:0] CFG_PULSE = 3'd4;

    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_BREATH = 2'd1;
    localparam logic [1:0] MODE_CYCLE  = 2'd2;
    localparam logic [1:0] MODE_PULSE  = 2'd3;

    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_R     = 3'd1;
    localparam logic [2:0] PH_RG    = 3'd2;
    localparam logic [2:0] PH_G     = 3'd3;
    localparam logic [2:0] PH_GB    = 3'd4;
    localparam logic [2:0] PH_B     = 3'd5;
    localparam logic [2:0] PH_BR    = 3'd6;
    localparam logic [2:0] PH_SPARE = 3'd7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LIM   = 3'd1;
    localparam logic [2:0] S_LIMW  = 3'd2;
    localparam logic [2:0] S_SCL   = 3'd3;
    localparam logic [2:0] S_SCLW  = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    typedef struct packed {
        logic             fall;
        logic [CNT_W-1:0] cnt;
    } t_ramp;

    function automatic t_ramp f_ramp(input logic [CNT_W-1:0] cnt, input logic fall,
                                     input logic [CNT_W-1:0] lim);
        t_ramp          res;
        logic [CNT_W:0] nxt;
        nxt = {1'b0, cnt} + (CNT_W+1)'(1);
        if (!fall) begin
            if (nxt > {1'b0, lim}) begin
                res.fall = 1'b1;
                res.cnt  = (cnt == '0) ? '0 : cnt - CNT_W'(1);
            end else begin
                res.fall = 1'b0;
                res.cnt  = nxt[CNT_W-1:0];
            end
        end else if (cnt == '0) begin
            res.fall = 1'b0;
            res.cnt  = CNT_W'(1);
        end else begin
            res.fall = 1'b1;
            res.cnt  = cnt - CNT_W'(1);
        end
        return res;
    endfunction

    // configuration registers
    logic [1:0]       r_mode;
    logic [LVL_W-1:0] r_red_lvl, r_green_lvl, r_blue_lvl, r_pulse;

    // sequencer
    logic [2:0]       r_state;
    logic [1:0]       r_ch;
    logic [QUO_W-1:0] r_prod;
    logic [CNT_W-1:0] r_limit;
    logic [LVL_W-1:0] r_sc_r, r_sc_g, r_sc_b;

    // ramp and compare state
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_fall, n_fall;
    logic [2:0]       r_phase, n_phase;
    logic [LVL_W-1:0] r_red, n_red, r_green, n_green, r_blue, n_blue;

    // output register
    logic             r_out_valid;
    logic [LVL_W-1:0] r_out_r, r_out_g, r_out_b;

    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic [LVL_W-1:0]         mul_a;
    logic [CNT_W-1:0]         mul_b;
    logic [QUO_W-1:0]         mul_p;
    logic [QUO_W+RCP_W-1:0]   lim_prod;
    logic [LVL_W-1:0]         sc_val;
    t_ramp                    stp;
    logic [LVL_W-1:0]         d;
    logic                     in_acc;
    logic                     out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // the one multiplier: pulse length times steps first, then level times count
    always_comb begin
        mul_a = LVL_MAX;
        mul_b = r_cnt;
        if (r_state == S_LIM) begin
            mul_a = r_pulse;
            mul_b = RampSteps;
        end else if (r_mode == MODE_BREATH) begin
            unique case (r_ch)
                CH_R:    mul_a = r_red_lvl;
                CH_G:    mul_a = r_green_lvl;
                default: mul_a = r_blue_lvl;
            endcase
        end
    end

    assign mul_p = QUO_W'(mul_a) * QUO_W'(mul_b);

    // ramp limit: the registered product divided by 255 through its reciprocal
    assign lim_prod = (QUO_W+RCP_W)'(r_prod) * (QUO_W+RCP_W)'(RCP_255);

    assign div_req.start    = (r_state == S_SCL);
    assign div_req.dividend = mul_p;
    assign div_req.divisor  = r_limit;

    rbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // zero limit gives duty 0, a quotient above full scale saturates
    always_comb begin
        if (r_limit == '0) begin
            sc_val = '0;
        end else if (|div_rsp.quot[QUO_W-1:LVL_W]) begin
            sc_val = LVL_MAX;
        end else begin
            sc_val = div_rsp.quot[LVL_W-1:0];
        end
    end

    assign stp = f_ramp(r_cnt, r_fall, r_limit);
    assign d   = r_sc_r;

    always_comb begin
        n_cnt   = r_cnt;
        n_fall  = r_fall;
        n_phase = r_phase;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        if (r_state == S_APPLY) begin
            unique case (r_mode)
                MODE_STEADY: begin
                    n_red   = r_red_lvl;
                    n_green = r_green_lvl;
                    n_blue  = r_blue_lvl;
                end
                MODE_BREATH: begin
                    n_red   = r_sc_r;
                    n_green = r_sc_g;
                    n_blue  = r_sc_b;
                    n_cnt   = stp.cnt;
                    n_fall  = stp.fall;
                end
                MODE_CYCLE: begin
                    unique case (r_phase)
                        PH_R: begin
                            n_blue = d;
                            if (!stp.fall) n_phase = PH_RG;
                        end
                        PH_RG: begin
                            n_green = d;
                            if (stp.fall) n_phase = PH_G;
                        end
                        PH_G: begin
                            n_red = d;
                            if (!stp.fall) n_phase = PH_GB;
                        end
                        PH_GB: begin
                            n_blue = d;
                            if (stp.fall) n_phase = PH_B;
                        end
                        PH_B: begin
                            n_green = d;
                            if (!stp.fall) n_phase = PH_BR;
                        end
                        PH_BR: begin
                            n_red = d;
                            if (stp.fall) n_phase = PH_R;
                        end
                        default: begin
                            n_red = LVL_MAX;
                        end
                    endcase
                    if (r_phase == PH_INIT || r_phase == PH_SPARE) begin
                        n_cnt   = CNT_W'(1);
                        n_fall  = 1'b0;
                        n_phase = PH_RG;
                    end else begin
                        n_cnt  = stp.cnt;
                        n_fall = stp.fall;
                    end
                end
                MODE_PULSE: begin
                    unique case (r_phase)
                        PH_R:  n_red = d;
                        PH_RG: begin
                            n_red   = d;
                            n_green = d;
                        end
                        PH_G:  n_green = d;
                        PH_GB: begin
                            n_green = d;
                            n_blue  = d;
                        end
                        PH_B:  n_blue = d;
                        PH_BR: begin
                            n_red  = d;
                            n_blue = d;
                        end
                        default: begin
                        end
                    endcase
                    if (r_phase == PH_INIT || r_phase == PH_SPARE) begin
                        n_cnt   = CNT_W'(1);
                        n_fall  = 1'b0;
                        n_phase = PH_R;
                    end else begin
                        n_cnt  = stp.cnt;
                        n_fall = stp.fall;
                        // phase moves on when the ramp restarts from the bottom
                        if (!stp.fall && stp.cnt == CNT_W'(1)) begin
                            n_phase = (r_phase == PH_BR) ? PH_R : r_phase + 3'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STEADY;
            r_red_lvl   <= '0;
            r_green_lvl <= '0;
            r_blue_lvl  <= '0;
            r_pulse     <= LVL_MAX;
            r_state     <= S_IDLE;
            r_ch        <= CH_R;
            r_cnt       <= '0;
            r_fall      <= 1'b0;
            r_phase     <= PH_INIT;
            r_red       <= '0;
            r_green     <= '0;
            r_blue      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:  r_mode      <= i_cfg_data[1:0];
                    CFG_RED:   r_red_lvl   <= i_cfg_data;
                    CFG_GREEN: r_green_lvl <= i_cfg_data;
                    CFG_BLUE:  r_blue_lvl  <= i_cfg_data;
                    CFG_PULSE: r_pulse     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_cnt   <= n_cnt;
            r_fall  <= n_fall;
            r_phase <= n_phase;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_update) begin
                            r_state <= S_OUT;
                        end else if (r_mode == MODE_STEADY) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_state <= S_LIM;
                        end
                    end
                end
                S_LIM: begin
                    r_prod  <= mul_p;
                    r_state <= S_LIMW;
                end
                S_LIMW: begin
                    r_limit <= lim_prod[RCP_SH +: CNT_W];
                    r_ch    <= CH_R;
                    r_state <= S_SCL;
                end
                S_SCL: r_state <= S_SCLW;
                S_SCLW: begin
                    if (div_rsp.done) begin
                        unique case (r_ch)
                            CH_R:    r_sc_r <= sc_val;
                            CH_G:    r_sc_g <= sc_val;
                            default: r_sc_b <= sc_val;
                        endcase
                        if (r_mode == MODE_BREATH && r_ch != CH_B) begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_SCL;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_APPLY: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_r <= r_red;
            r_out_g <= r_green;
            r_out_b <= r_blue;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_duty   = r_out_r;
    assign o_green_duty = r_out_g;
    assign o_blue_duty  = r_out_b;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("sequencer ready right after taking an item");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_SCLW))
        else $error("divider finished while no state waits for it");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch != 2'd3)
        else $error("scaled channel index out of range");

    a_state_only_update_in_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> ($stable(r_phase) && $stable(r_cnt)))
        else $error("ramp or phase changed outside the apply step");

endmodule

>>> hw/rtl/rbc_div.sv
// serial restoring divider, one quotient bit per cycle
module rbc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rbc_pkg::t_div_req i_req,
    output rbc_pkg::t_div_rsp o_rsp
);
    import rbc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_quo;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W:0]    diff;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUO_W);
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                // dividend shifts out at the top as quotient bits shift in
                r_rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                r_quo  <= {r_quo[QUO_W-2:0], fits};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> tb/sv/rgb_led_breathe_cycle_tb_pkg.sv
`timescale 1ns / 100ps
// register indexes, modes, colour phases and the duty triple shared by the testbench files
package rbc_tb_pkg;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_RED    = 3'd1,
        REG_GREEN  = 3'd2,
        REG_BLUE   = 3'd3,
        REG_PULSE  = 3'd4,
        REG_SPARE5 = 3'd5,
        REG_SPARE6 = 3'd6,
        REG_SPARE7 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_STEADY  = 2'd0,
        MODE_BREATHE = 2'd1,
        MODE_CYCLE   = 2'd2,
        MODE_PULSE   = 2'd3
    } t_led_mode;

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_R     = 3'd1,
        PH_RG    = 3'd2,
        PH_G     = 3'd3,
        PH_GB    = 3'd4,
        PH_B     = 3'd5,
        PH_BR    = 3'd6,
        PH_SPARE = 3'd7
    } t_colour_phase;

    typedef struct packed {
        logic [rbc_pkg::LVL_W-1:0] red;
        logic [rbc_pkg::LVL_W-1:0] green;
        logic [rbc_pkg::LVL_W-1:0] blue;
    } t_duty_set;

endpackage

>>> tb/sv/rgb_led_breathe_cycle_checker.sv
`timescale 1ns / 100ps
// duty checker: shadows the registers, predicts each item's compare values and matches results
module rgb_led_breathe_cycle_checker #(
    parameter int RAMP_STEPS = 5000
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_update,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [rbc_pkg::LVL_W-1:0] i_red,
    input  logic [rbc_pkg::LVL_W-1:0] i_green,
    input  logic [rbc_pkg::LVL_W-1:0] i_blue,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [rbc_pkg::LVL_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    import rbc_tb_pkg::*;

    t_led_mode                 mode_r;
    logic [rbc_pkg::LVL_W-1:0] red_lvl, green_lvl, blue_lvl, pulse_len;

    logic [rbc_pkg::CNT_W-1:0] ramp_cnt;
    logic                      ramp_fall;
    t_colour_phase             phase;
    logic [rbc_pkg::LVL_W-1:0] red_cmp, green_cmp, blue_cmp;

    t_duty_set duty_q[$];
    int        fail_cnt    = 0;
    int        checked_cnt = 0;
    int        pend_cnt    = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;
    assign o_checked    = checked_cnt;

    task automatic note_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic void clear_state();
        mode_r    = MODE_STEADY;
        red_lvl   = '0;
        green_lvl = '0;
        blue_lvl  = '0;
        pulse_len = 8'd255;
        ramp_cnt  = '0;
        ramp_fall = 1'b0;
        phase     = PH_INIT;
        red_cmp   = '0;
        green_cmp = '0;
        blue_cmp  = '0;
    endfunction

    function automatic void write_shadow(input t_reg_idx idx, input logic [7:0] data);
        case (idx)
            REG_MODE:  mode_r    = t_led_mode'(data[1:0]);
            REG_RED:   red_lvl   = data;
            REG_GREEN: green_lvl = data;
            REG_BLUE:  blue_lvl  = data;
            REG_PULSE: pulse_len = data;
            default: ;
        endcase
    endfunction

    // level * count / limit, truncated, clipped at full scale when the limit was lowered
    function automatic logic [7:0] scaled(input logic [7:0] lvl, input int unsigned lim);
        int unsigned q;
        if (lim == 0)
            return 8'd0;
        q = (32'(lvl) * 32'(ramp_cnt)) / lim;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void advance_ramp(input int unsigned lim);
        if (!ramp_fall) begin
            if (32'(ramp_cnt) + 1 > lim) begin
                ramp_fall = 1'b1;
                ramp_cnt  = (ramp_cnt == 0) ? ramp_cnt : ramp_cnt - 1'b1;
            end else begin
                ramp_cnt = ramp_cnt + 1'b1;
            end
        end else if (ramp_cnt == 0) begin
            ramp_fall = 1'b0;
            ramp_cnt  = rbc_pkg::CNT_W'(1);
        end else begin
            ramp_cnt = ramp_cnt - 1'b1;
        end
    endfunction

    // fade one channel per phase, move on when the ramp turns
    function automatic void colour_step(input int unsigned lim);
        logic [7:0] d;
        d = scaled(8'd255, lim);
        case (phase)
            PH_R: begin
                blue_cmp = d;
                advance_ramp(lim);
                if (!ramp_fall) phase = PH_RG;
            end
            PH_RG: begin
                green_cmp = d;
                advance_ramp(lim);
                if (ramp_fall) phase = PH_G;
            end
            PH_G: begin
                red_cmp = d;
                advance_ramp(lim);
                if (!ramp_fall) phase = PH_GB;
            end
            PH_GB: begin
                blue_cmp = d;
                advance_ramp(lim);
                if (ramp_fall) phase = PH_B;
            end
            PH_B: begin
                green_cmp = d;
                advance_ramp(lim);
                if (!ramp_fall) phase = PH_BR;
            end
            PH_BR: begin
                red_cmp = d;
                advance_ramp(lim);
                if (ramp_fall) phase = PH_R;
            end
            default: begin
                ramp_cnt  = rbc_pkg::CNT_W'(1);
                ramp_fall = 1'b0;
                phase     = PH_RG;
                red_cmp   = 8'd255;
            end
        endcase
    endfunction

    // breathe one or two channels, next phase when the ramp restarts at one
    function automatic void pulse_step(input int unsigned lim);
        logic [7:0] d;
        d = scaled(8'd255, lim);
        case (phase)
            PH_R:  red_cmp = d;
            PH_RG: begin
                red_cmp   = d;
                green_cmp = d;
            end
            PH_G:  green_cmp = d;
            PH_GB: begin
                green_cmp = d;
                blue_cmp  = d;
            end
            PH_B:  blue_cmp = d;
            PH_BR: begin
                red_cmp  = d;
                blue_cmp = d;
            end
            default: begin
                ramp_cnt  = rbc_pkg::CNT_W'(1);
                ramp_fall = 1'b0;
                phase     = PH_R;
                return;
            end
        endcase
        advance_ramp(lim);
        if (!ramp_fall && ramp_cnt == 1)
            phase = (phase == PH_BR) ? PH_R : t_colour_phase'(phase + 3'd1);
    endfunction

    function automatic t_duty_set next_duties(input logic upd);
        int unsigned lim;
        t_duty_set   res;
        lim = (32'(pulse_len) * RAMP_STEPS) / 255;
        if (upd) begin
            case (mode_r)
                MODE_STEADY: begin
                    red_cmp   = red_lvl;
                    green_cmp = green_lvl;
                    blue_cmp  = blue_lvl;
                end
                MODE_BREATHE: begin
                    red_cmp   = scaled(red_lvl, lim);
                    green_cmp = scaled(green_lvl, lim);
                    blue_cmp  = scaled(blue_lvl, lim);
                    advance_ramp(lim);
                end
                MODE_CYCLE: colour_step(lim);
                default:    pulse_step(lim);
            endcase
        end
        res.red   = red_cmp;
        res.green = green_cmp;
        res.blue  = blue_cmp;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            note_failure($sformatf("%s duty got %0d expected %0d", name, got, want));
    endtask

    initial clear_state();

    always @(posedge i_clk) begin : watch
        t_duty_set want;
        if (!i_rst_n) begin
            clear_state();
            duty_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_shadow(t_reg_idx'(i_cfg_index), i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (duty_q.size() == 0) begin
                    note_failure($sformatf("result %0d/%0d/%0d with no item waiting",
                                           i_red, i_green, i_blue));
                end else begin
                    want = duty_q.pop_front();
                    check_field("red", i_red, want.red);
                    check_field("green", i_green, want.green);
                    check_field("blue", i_blue, want.blue);
                    checked_cnt++;
                end
            end
            if (i_in_valid && i_in_ready)
                duty_q.push_back(next_duties(i_update));
        end
        pend_cnt <= duty_q.size();
    end

endmodule

>>> tb/sv/rgb_led_breathe_cycle_top_test.sv
`timescale 1ns / 100ps
// top of the rgb breathe testbench: clock, reset, register writes, tick stimulus and verdict
module rgb_led_breathe_cycle_top_test;
    import rbc_tb_pkg::*;

    localparam int RAMP_STEPS  = 5000;
    localparam int N_ITEMS     = 1600;
    localparam int HOLD_CYCLES = 120;

    typedef enum {SC_STEADY, SC_BREATHE, SC_CYCLE, SC_PULSE, SC_SHRINK} t_scene;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      i_update    = 1'b0;
    logic                      i_out_ready = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [2:0]                i_cfg_index = REG_MODE;
    logic [rbc_pkg::LVL_W-1:0] i_cfg_data  = '0;
    logic                      o_in_ready, o_out_valid, o_cfg_ready;
    logic [rbc_pkg::LVL_W-1:0] o_red_duty, o_green_duty, o_blue_duty;

    int       fail_count, pending, checked;
    int       n_ticks    = 0;
    int       n_writes   = 0;
    logic [3:0] modes_seen = '0;
    logic     burst      = 1'b0;   // no idling on either side while set

    rgb_led_breathe_cycle_top #(
        .RAMP_STEPS(RAMP_STEPS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_update    (i_update),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red_duty  (o_red_duty),
        .o_green_duty(o_green_duty),
        .o_blue_duty (o_blue_duty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rgb_led_breathe_cycle_checker #(
        .RAMP_STEPS(RAMP_STEPS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_update    (i_update),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_red       (o_red_duty),
        .i_green     (o_green_duty),
        .i_blue      (o_blue_duty),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("run did not finish within its time budget");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // entered and left at a falling edge; valid stays up for a back-to-back item
    task automatic send_tick(input logic upd);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_update   <= upd;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
        n_ticks++;
    endtask

    task automatic run_ticks(input int n, input int update_pct);
        repeat (n) send_tick($urandom_range(0, 99) < update_pct);
    endtask

    // hold the sender until every result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_writes++;
    endtask

    // upper data bits are random so the mode field masking gets exercised
    task automatic set_mode(input t_led_mode m);
        write_reg(REG_MODE, {6'($urandom), m});
        modes_seen[m] = 1'b1;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly short ramps so the colour phases turn over often
    function automatic logic [7:0] pick_pulse();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic load_levels();
        write_reg(REG_RED, pick_level());
        write_reg(REG_GREEN, pick_level());
        write_reg(REG_BLUE, pick_level());
    endtask

    initial begin : receiver
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_scene scene;
        int     n_phase;
        int     start_ticks;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, then steady with zero levels
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
        write_reg(REG_RED, 8'd255);
        write_reg(REG_GREEN, 8'd0);
        write_reg(REG_BLUE, 8'd170);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();
        // writes to unused indexes must change nothing
        write_reg(REG_SPARE5, 8'h5A);
        write_reg(REG_SPARE7, 8'hFF);
        send_tick(1'b1);
        settle();
        // zero ramp limit: duties stay 0 and the ramp turns on zero
        set_mode(MODE_BREATHE);
        write_reg(REG_PULSE, 8'd0);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        settle();
        write_reg(REG_PULSE, 8'd255);
        repeat (3) send_tick(1'b1);
        settle();
        // first colour cycle tick leaves the init phase
        set_mode(MODE_CYCLE);
        write_reg(REG_PULSE, 8'd1);
        repeat (4) send_tick(1'b1);
        settle();
        set_mode(MODE_PULSE);
        repeat (3) send_tick(1'b1);

        start_ticks = n_ticks;
        n_phase     = 0;
        while (n_ticks - start_ticks < N_ITEMS) begin
            settle();
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                write_reg(t_reg_idx'($urandom_range(REG_SPARE5, REG_SPARE7)), 8'($urandom));
            scene = (n_phase < 5) ? t_scene'(n_phase) : t_scene'($urandom_range(0, 4));
            case (scene)
                SC_STEADY: begin
                    set_mode(MODE_STEADY);
                    load_levels();
                    run_ticks($urandom_range(15, 40), 80);
                end
                SC_BREATHE: begin
                    set_mode(MODE_BREATHE);
                    load_levels();
                    write_reg(REG_PULSE, pick_pulse());
                    run_ticks($urandom_range(40, 120), 85);
                end
                SC_CYCLE: begin
                    set_mode(MODE_CYCLE);
                    write_reg(REG_PULSE, pick_pulse());
                    run_ticks($urandom_range(60, 200), 90);
                end
                SC_PULSE: begin
                    set_mode(MODE_PULSE);
                    write_reg(REG_PULSE, pick_pulse());
                    run_ticks($urandom_range(60, 200), 90);
                end
                default: begin
                    // climb a longer ramp, then shrink the limit under the count
                    set_mode(MODE_BREATHE);
                    write_reg(REG_RED, 8'd255);
                    write_reg(REG_GREEN, pick_level());
                    write_reg(REG_BLUE, pick_level());
                    write_reg(REG_PULSE, 8'd3);
                    run_ticks($urandom_range(30, 50), 100);
                    settle();
                    write_reg(REG_PULSE, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd1);
                    run_ticks($urandom_range(10, 30), 100);
                end
            endcase
            n_phase++;
        end

        burst = 1'b0;
        i_in_valid <= 1'b0;
        repeat (5000) begin
            if (pending == 0)
                break;
            @(posedge i_clk);
        end
        repeat (HOLD_CYCLES) @(posedge i_clk);

        if (pending != 0)
            $display("%0d results never arrived", pending);
        $display("%0d ticks over %0d stimulus phases, modes exercised %b, %0d register writes",
                 n_ticks, n_phase, modes_seen, n_writes);
        $display("%0d results compared against the predicted duties", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
